### sv/nsqm_pkg.sv
// Shared constants and types for the named stack/queue manager.
// Holds pool sizes, derived widths, operation and status codes, and the
// controller-to-datapath command struct. No dependencies.
package nsqm_pkg;

    // Pool sizes
    localparam int LISTS      = 16;
    localparam int ENTRIES    = 256;
    localparam int DATA_WIDTH = 32;

    // Derived widths
    localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int PTR_W  = $clog2(ENTRIES);
    localparam int CNT_W  = PTR_W + 1;

    // Request and result field widths
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_LIST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // Controller commands to the datapath
    typedef struct packed {
        logic accept;   // capture request, launch memory reads
        logic commit;   // write state back and load the result register
    } t_ctrl_cmd;

endpackage

### sv/nsqm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Contents are undefined until written. No dependencies.
module nsqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/nsqm_ctrl.sv
// Controller for the stack/queue manager: request sequencing and the
// result valid flag. Depends on nsqm_pkg.
module nsqm_ctrl
    import nsqm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   commit;

    // Take a request only when idle and out of reset; commit once the result slot frees up
    assign accept = (r_state == S_IDLE) && i_in_valid && i_rst_n;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result valid: set on commit, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.commit = commit;

    // Checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule

### sv/nsqm_dpath.sv
// Datapath for the stack/queue manager: per-list pointer registers, the
// entry value/link memories, the free-entry stack and the result register.
// Depends on nsqm_pkg and nsqm_ram.
module nsqm_dpath
    import nsqm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [ID_W-1:0]       i_list_id,
    input  logic                  i_kind,
    input  logic [VALUE_W-1:0]    i_value,
    output logic [STATUS_W-1:0]   o_status,
    output logic [VALUE_W-1:0]    o_popped_value,
    output logic                  o_popped_valid
);

    // Captured request
    logic [FUNC_W-1:0]     r_func;
    logic [ID_W-1:0]       r_id;
    logic                  r_kind;
    logic [DATA_WIDTH-1:0] r_value;

    // Per-list state
    logic             r_exists [LISTS];
    logic             r_is_queue [LISTS];
    logic [PTR_W-1:0] r_head [LISTS];
    logic [PTR_W-1:0] r_tail [LISTS];
    logic [CNT_W-1:0] r_count [LISTS];

    // Free-entry stack top, and lowest top ever reached: slots below it
    // were never written and stand for their own index
    logic [CNT_W-1:0] r_free_top;
    logic [CNT_W-1:0] r_fresh;

    // Result register
    logic [STATUS_W-1:0] r_status;
    logic [VALUE_W-1:0]  r_popped;
    logic                r_popped_valid;

    // Memory read data
    logic [DATA_WIDTH-1:0] val_rdata;
    logic [PTR_W-1:0]      link_rdata;
    logic [PTR_W-1:0]      free_rdata;

    logic [LIST_W-1:0] in_idx;
    logic [LIST_W-1:0] idx;
    logic              known;
    logic              exists;
    logic              list_empty;
    logic              do_create;
    logic              do_push;
    logic              do_pop;
    logic [STATUS_W-1:0] status;
    logic [PTR_W-1:0]  new_e;
    logic              fresh_slot;
    logic              link_we;
    logic [PTR_W-1:0]  link_waddr;
    logic [PTR_W-1:0]  link_wdata;
    logic              free_we;
    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  n_tail;
    logic [CNT_W-1:0]  n_count;

    assign in_idx     = LIST_W'(i_list_id);
    assign idx        = LIST_W'(r_id);
    assign known      = (32'(r_id) < LISTS);
    assign exists     = known && r_exists[idx];
    assign list_empty = (r_count[idx] == '0);

    // Decode the request and its status
    always_comb begin
        status    = ST_OK;
        do_create = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        unique case (r_func)
            FUNC_CREATE: begin
                if (!known) begin
                    status = ST_NO_LIST;
                end else if (r_exists[idx]) begin
                    status = ST_EXISTS;
                end else begin
                    do_create = i_cmd.commit;
                end
            end
            FUNC_PUSH: begin
                if (!exists) begin
                    status = ST_NO_LIST;
                end else if (r_free_top == '0) begin
                    status = ST_FULL;
                end else begin
                    do_push = i_cmd.commit;
                end
            end
            FUNC_POP: begin
                if (!exists) begin
                    status = ST_NO_LIST;
                end else if (list_empty) begin
                    status = ST_EMPTY;
                end else begin
                    do_pop = i_cmd.commit;
                end
            end
            default: status = ST_OK;
        endcase
    end

    // Pick the entry to allocate from the free stack
    assign fresh_slot = (r_free_top == r_fresh);
    assign new_e      = fresh_slot ? PTR_W'(r_free_top - CNT_W'(1)) : free_rdata;

    // Link write: queue appends behind the tail, stack links new head
    assign link_we    = do_push && !list_empty;
    assign link_waddr = r_is_queue[idx] ? r_tail[idx] : new_e;
    assign link_wdata = r_is_queue[idx] ? new_e : r_head[idx];

    // Return the popped entry while the stack has room
    assign free_we = do_pop && (r_free_top < CNT_W'(ENTRIES));

    // Next pointers of the selected list
    always_comb begin
        n_head  = r_head[idx];
        n_tail  = r_tail[idx];
        n_count = r_count[idx];
        priority if (do_create) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else if (do_push) begin
            n_count = r_count[idx] + CNT_W'(1);
            if (list_empty) begin
                n_head = new_e;
                n_tail = new_e;
            end else if (r_is_queue[idx]) begin
                n_tail = new_e;
            end else begin
                n_head = new_e;
            end
        end else if (do_pop) begin
            n_count = r_count[idx] - CNT_W'(1);
            if (r_count[idx] == CNT_W'(1)) begin
                n_head = '0;
                n_tail = '0;
            end else begin
                n_head = link_rdata;
            end
        end else begin
            n_count = r_count[idx];
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_id    <= i_list_id;
            r_kind  <= i_kind;
            r_value <= DATA_WIDTH'(i_value);
        end
    end

    // List and free-stack state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LISTS; i++) begin
                r_exists[i]   <= 1'b0;
                r_is_queue[i] <= 1'b0;
                r_head[i]     <= '0;
                r_tail[i]     <= '0;
                r_count[i]    <= '0;
            end
            r_free_top <= CNT_W'(ENTRIES);
            r_fresh    <= CNT_W'(ENTRIES);
        end else begin
            if (do_create) begin
                r_exists[idx]   <= 1'b1;
                r_is_queue[idx] <= r_kind;
            end
            if (do_create || do_push || do_pop) begin
                r_head[idx]  <= n_head;
                r_tail[idx]  <= n_tail;
                r_count[idx] <= n_count;
            end
            if (do_push) begin
                r_free_top <= r_free_top - CNT_W'(1);
                if (fresh_slot) begin
                    r_fresh <= r_free_top - CNT_W'(1);
                end
            end else if (free_we) begin
                r_free_top <= r_free_top + CNT_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status       <= status;
            r_popped       <= do_pop ? VALUE_W'(signed'(val_rdata)) : '0;
            r_popped_valid <= do_pop;
        end
    end

    // Entry values
    nsqm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (new_e),
        .i_wdata (r_value),
        .i_re    (i_cmd.accept),
        .i_raddr (r_head[in_idx]),
        .o_rdata (val_rdata)
    );

    // Entry links
    nsqm_ram #(
        .WIDTH (PTR_W),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (r_head[in_idx]),
        .o_rdata (link_rdata)
    );

    // Free-entry stack
    nsqm_ram #(
        .WIDTH (PTR_W),
        .DEPTH (ENTRIES)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (PTR_W'(r_free_top)),
        .i_wdata (r_head[idx]),
        .i_re    (i_cmd.accept),
        .i_raddr (PTR_W'(r_free_top - CNT_W'(1))),
        .o_rdata (free_rdata)
    );

    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_popped_valid = r_popped_valid;

    // Checks
    a_fresh_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= r_free_top)
        else $error("fresh mark above free-stack top");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= CNT_W'(ENTRIES))
        else $error("free-stack top beyond pool size");

    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (r_free_top == $past(r_free_top) + CNT_W'(1)))
        else $error("pop did not return its entry");

    a_push_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> (r_free_top == $past(r_free_top) - CNT_W'(1)))
        else $error("push did not take a free entry");

endmodule

### sv/named_stack_queue_manager.sv
// Named stack/queue manager: up to 16 numbered lists share a pool of 256
// entries. Each list is created once as a stack or a queue; pop takes the head.
//
// Request channel (s_axis): tdata carries func, list_id and value; tuser
// carries kind. Result channel (m_axis): tdata carries status and
// popped_value; tuser carries popped_valid. One result per request.
//
// Timing: a request is taken in the idle state; the execute state reads the
// list pointers and the entry/link/free-stack memories (registered reads
// launched at acceptance) and, once the result register is free, writes
// everything back, loading the result register. A new request is taken only
// after the previous one has committed, set by the memory read-then-write
// turn. The next request is taken while the previous result still waits.
//
// Reset (synchronous, active low) empties every list and returns all
// entries to the free pool at once; no clearing pass is needed. When the
// receiver stalls, a finished request holds in the execute step until the
// result register frees, and s_axis_tready stays low meanwhile.
// Depends on nsqm_pkg, nsqm_ctrl, nsqm_dpath and nsqm_ram.
module named_stack_queue_manager
    import nsqm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] func, [5:2] list_id, [37:6] value
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] popped_value
    output logic        m_axis_tuser    // [0] popped_valid
);

    t_ctrl_cmd           cmd;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped_value;
    logic                popped_valid;

    nsqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    nsqm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (s_axis_tdata[1:0]),
        .i_list_id      (s_axis_tdata[5:2]),
        .i_kind         (s_axis_tuser),
        .i_value        (s_axis_tdata[37:6]),
        .o_status       (status),
        .o_popped_value (popped_value),
        .o_popped_valid (popped_valid)
    );

    // Pack the result
    assign m_axis_tdata = {5'b0, popped_value, status};
    assign m_axis_tuser = popped_valid;

endmodule

### tb/sv/tb_named_stack_queue_manager.sv
// Testbench for named_stack_queue_manager: drives create/push/pop requests and
// checks every result against a behavioral model of the lists and entry pool.
// Depends on nsqm_pkg and the named_stack_queue_manager RTL.
`timescale 1ns / 100ps

module tb_named_stack_queue_manager;
    import nsqm_pkg::*;

    // Unused operation code: the block must answer ok and change nothing
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  popped_value;
        logic                popped_valid;
    } t_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [1:0] func, [5:2] list_id, [37:6] value
    logic        s_axis_tuser  = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [2:0] status, [34:3] popped_value
    logic        m_axis_tuser;         // [0] popped_valid

    // Model of list descriptors and the shared entry pool
    bit                    list_live [LISTS];
    bit                    list_fifo [LISTS];
    int unsigned           list_head [LISTS];
    int unsigned           list_tail [LISTS];
    int unsigned           list_cnt  [LISTS];
    logic [DATA_WIDTH-1:0] pool_value [ENTRIES];
    int unsigned           pool_link  [ENTRIES];
    int unsigned           free_list  [ENTRIES];
    int unsigned           free_top;
    int unsigned           peak_in_use;

    t_reply pending_replies[$];
    int     tx_idle_pct;
    int     rx_idle_pct;
    int     error_count;
    int     requests_sent;
    int     status_seen [8];
    int     values_popped;

    named_stack_queue_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Stall the result channel at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Apply one request to the model and return the reply it produces
    function automatic t_reply apply_list_command(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                                  logic kind, logic [VALUE_W-1:0] value);
        t_reply      r;
        bit          known;
        int unsigned e;
        r.status       = ST_OK;
        r.popped_value = '0;
        r.popped_valid = 1'b0;
        known = (id < LISTS);
        case (func)
            FUNC_CREATE: begin
                if (!known) begin
                    r.status = ST_NO_LIST;
                end else if (list_live[id]) begin
                    r.status = ST_EXISTS;
                end else begin
                    list_live[id] = 1'b1;
                    list_fifo[id] = kind;
                    list_head[id] = 0;
                    list_tail[id] = 0;
                    list_cnt[id]  = 0;
                end
            end
            FUNC_PUSH: begin
                if (!known || !list_live[id]) begin
                    r.status = ST_NO_LIST;
                end else if (free_top == 0) begin
                    r.status = ST_FULL;
                end else begin
                    free_top--;
                    e = free_list[free_top];
                    pool_value[e] = value[DATA_WIDTH-1:0];
                    if (list_cnt[id] == 0) begin
                        pool_link[e]  = 0;
                        list_head[id] = e;
                        list_tail[id] = e;
                    end else if (list_fifo[id]) begin
                        pool_link[e]             = 0;
                        pool_link[list_tail[id]] = e;
                        list_tail[id]            = e;
                    end else begin
                        pool_link[e]  = list_head[id];
                        list_head[id] = e;
                    end
                    list_cnt[id]++;
                    if (ENTRIES - free_top > peak_in_use) peak_in_use = ENTRIES - free_top;
                end
            end
            FUNC_POP: begin
                if (!known || !list_live[id]) begin
                    r.status = ST_NO_LIST;
                end else if (list_cnt[id] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = list_head[id];
                    r.popped_value = VALUE_W'($signed(pool_value[e]));
                    r.popped_valid = 1'b1;
                    list_head[id]  = pool_link[e];
                    list_cnt[id]--;
                    if (list_cnt[id] == 0) begin
                        list_head[id] = 0;
                        list_tail[id] = 0;
                    end
                    if (free_top < ENTRIES) begin
                        free_list[free_top] = e;
                        free_top++;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one request, with a random idle gap first; must start on a clock edge
    task automatic send_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id, logic kind,
                                logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, value, id, func};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(apply_list_command(func, id, kind, value));
        requests_sent++;
    endtask

    // Hold off new requests until every reply is back
    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Find a non-empty list, scanning from a random start; returns LISTS if none
    function automatic int find_busy_list();
        int start;
        int k;
        start = $urandom_range(LISTS - 1);
        for (k = 0; k < LISTS; k++) begin
            if (list_cnt[(start + k) % LISTS] != 0) return (start + k) % LISTS;
        end
        return LISTS;
    endfunction

    // Error codes, LIFO and FIFO order, extreme values, unused operation
    task automatic test_directed();
        send_request(FUNC_POP,    4'd3,  1'b0, '0);
        send_request(FUNC_PUSH,   4'd3,  1'b0, 32'd7);
        send_request(FUNC_CREATE, 4'd0,  1'b0, '0);
        send_request(FUNC_CREATE, 4'd0,  1'b1, '0);
        send_request(FUNC_POP,    4'd0,  1'b0, '0);
        // stack: first push also sets the tail
        send_request(FUNC_PUSH,   4'd0,  1'b0, VAL_MIN);
        send_request(FUNC_PUSH,   4'd0,  1'b0, VAL_MAX);
        send_request(FUNC_PUSH,   4'd0,  1'b0, '0);
        send_request(FUNC_PUSH,   4'd0,  1'b0, '1);
        repeat (5) send_request(FUNC_POP, 4'd0, 1'b0, '0);
        // queue on the highest id
        send_request(FUNC_CREATE, 4'd15, 1'b1, '1);
        send_request(FUNC_PUSH,   4'd15, 1'b1, 32'h0000_0001);
        send_request(FUNC_PUSH,   4'd15, 1'b1, 32'ha5a5_a5a5);
        send_request(FUNC_PUSH,   4'd15, 1'b1, 32'h5a5a_5a5a);
        repeat (4) send_request(FUNC_POP, 4'd15, 1'b1, '0);
        // refill after the pointers were cleared
        send_request(FUNC_PUSH,   4'd15, 1'b0, VAL_MAX);
        send_request(FUNC_POP,    4'd15, 1'b0, '0);
        send_request(FUNC_NOP,    4'd7,  1'b1, '1);
    endtask

    // Random mix weighted toward push and pop on any id
    task automatic test_random_mix(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_request(FUNC_CREATE, ID_W'($urandom_range(15)), 1'($urandom_range(1)),
                             $urandom);
            else if (pick < 12)
                send_request(FUNC_NOP, ID_W'($urandom_range(15)), 1'($urandom_range(1)),
                             $urandom);
            else if (pick < 57)
                send_request(FUNC_PUSH, ID_W'($urandom_range(15)), 1'($urandom_range(1)),
                             pick_value());
            else
                send_request(FUNC_POP, ID_W'($urandom_range(15)), 1'($urandom_range(1)),
                             $urandom);
        end
    endtask

    // Fill the whole pool, then hit the store-full case around one freed entry
    task automatic test_pool_exhaust();
        int id;
        for (id = 0; id < LISTS; id++)
            send_request(FUNC_CREATE, ID_W'(id), 1'($urandom_range(1)), $urandom);
        while (free_top != 0)
            send_request(FUNC_PUSH, ID_W'($urandom_range(15)), 1'($urandom_range(1)),
                         pick_value());
        repeat (3) send_request(FUNC_PUSH, ID_W'($urandom_range(15)), 1'b0, pick_value());
        send_request(FUNC_POP, ID_W'(find_busy_list()), 1'b0, '0);
        send_request(FUNC_PUSH, ID_W'($urandom_range(15)), 1'b1, pick_value());
        send_request(FUNC_PUSH, ID_W'($urandom_range(15)), 1'b0, pick_value());
    endtask

    // Pop every list back to empty, then pop a few empty lists
    task automatic test_pool_drain();
        int id;
        id = find_busy_list();
        while (id < LISTS) begin
            send_request(FUNC_POP, ID_W'(id), 1'($urandom_range(1)), $urandom);
            id = find_busy_list();
        end
        repeat (3) send_request(FUNC_POP, ID_W'($urandom_range(15)), 1'b0, '0);
    endtask

    // Compare each result with the oldest expected reply
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                status_seen[m_axis_tdata[2:0]]++;
                if (m_axis_tuser === 1'b1) values_popped++;
                if (m_axis_tdata[2:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[34:3] !== want.popped_value) begin
                    $error("popped_value: expected %h, got %h",
                           want.popped_value, m_axis_tdata[34:3]);
                    error_count++;
                end
                if (m_axis_tuser !== want.popped_valid) begin
                    $error("popped_valid: expected %b, got %b",
                           want.popped_valid, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #3_000_000;
        $display("tb_named_stack_queue_manager NOT OK");
        $finish;
    end

    initial begin : run_tests
        int k;
        // Reset the model alongside the block
        for (k = 0; k < LISTS; k++) begin
            list_live[k] = 1'b0;
            list_fifo[k] = 1'b0;
            list_head[k] = 0;
            list_tail[k] = 0;
            list_cnt[k]  = 0;
        end
        for (k = 0; k < ENTRIES; k++) free_list[k] = k;
        free_top      = ENTRIES;
        peak_in_use   = 0;
        error_count   = 0;
        requests_sent = 0;
        values_popped = 0;
        for (k = 0; k < 8; k++) status_seen[k] = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 52;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(150);
        wait_for_replies();

        tx_idle_pct = 52;
        rx_idle_pct = 18;
        test_random_mix(150);
        test_pool_exhaust();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_pool_drain();
        test_random_mix(10);

        // Drain and allow a few cycles for any stray result
        wait_for_replies();
        repeat (6) @(posedge i_clk);

        $display("%0d requests: %0d ok, %0d exists, %0d no list, %0d empty, %0d full",
                 requests_sent, status_seen[ST_OK], status_seen[ST_EXISTS],
                 status_seen[ST_NO_LIST], status_seen[ST_EMPTY], status_seen[ST_FULL]);
        $display("%0d values popped, peak pool use %0d of %0d entries",
                 values_popped, peak_in_use, ENTRIES);
        if (error_count == 0)
            $display("tb_named_stack_queue_manager OK");
        else
            $display("tb_named_stack_queue_manager NOT OK");
        $finish;
    end

endmodule
